FILE: src/mrm_pkg.sv
// shared constants and types of the multichannel running median filter
`default_nettype none

package mrm_pkg;

    // window length, channel count and kept sample width
    localparam int WINDOW      = 3;
    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 32;

    // fixed widths of the word fields
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 32;

    // samples are kept at most this wide, as two's complement
    localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RANK_W   = $clog2(WINDOW + 1);

    // middle position of the sorted window and its parity
    localparam int MID         = WINDOW / 2;
    localparam bit ODD_WINDOW  = (WINDOW % 2) != 0;

    typedef logic [KEEP_BITS-1:0]             t_sample;
    typedef logic [WINDOW-1:0][KEEP_BITS-1:0] t_row;
    typedef logic [CH_IDX_W-1:0]              t_ch_idx;
    typedef logic [RANK_W-1:0]                t_rank;

endpackage

`default_nettype wire

FILE: src/mrm_if.sv
// word channels of the running median filter
`default_nettype none

interface mrm_in_if;
    logic                              valid;
    logic                              ready;
    logic [mrm_pkg::CH_W-1:0]          channel;
    logic signed [mrm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mrm_out_if;
    logic                              valid;
    logic                              ready;
    logic [mrm_pkg::CH_W-1:0]          channel_out;
    logic signed [mrm_pkg::SAMPLE_W-1:0] median_value;

    modport source (output valid, output channel_out, output median_value, input ready);
    modport sink   (input valid, input channel_out, input median_value, output ready);
endinterface

`default_nettype wire

FILE: src/mrm_median.sv
// rank-compare median of one window of samples
`default_nettype none

module mrm_median (
    input  wire mrm_pkg::t_row                  i_row,
    output logic signed [mrm_pkg::SAMPLE_W-1:0] o_median
);

    mrm_pkg::t_rank                          rank [mrm_pkg::WINDOW];
    logic signed [mrm_pkg::KEEP_BITS-1:0]    mid_hi;
    logic signed [mrm_pkg::KEEP_BITS-1:0]    mid_lo;
    logic signed [mrm_pkg::KEEP_BITS:0]      pair_sum;
    logic signed [mrm_pkg::KEEP_BITS-1:0]    half;

    // rank of each element, ties broken by position so ranks are unique
    always_comb begin
        for (int i = 0; i < mrm_pkg::WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < mrm_pkg::WINDOW; j++) begin
                if (j != i) begin
                    if (($signed(i_row[j]) < $signed(i_row[i])) ||
                        ((i_row[j] == i_row[i]) && (j < i))) begin
                        rank[i] = rank[i] + mrm_pkg::t_rank'(1);
                    end
                end
            end
        end
    end

    // pick the middle element(s) by rank
    always_comb begin
        mid_hi = '0;
        mid_lo = '0;
        for (int i = 0; i < mrm_pkg::WINDOW; i++) begin
            if (rank[i] == mrm_pkg::t_rank'(mrm_pkg::MID)) begin
                mid_hi = mid_hi | $signed(i_row[i]);
            end
            if (rank[i] == mrm_pkg::t_rank'(mrm_pkg::MID - 1)) begin
                mid_lo = mid_lo | $signed(i_row[i]);
            end
        end
    end

    // even window: mean of the two middle values, rounded toward minus infinity
    always_comb begin
        pair_sum = (mrm_pkg::KEEP_BITS+1)'(mid_hi) + (mrm_pkg::KEEP_BITS+1)'(mid_lo);
        half     = $signed(pair_sum[mrm_pkg::KEEP_BITS:1]);
        if (mrm_pkg::ODD_WINDOW) begin
            o_median = mrm_pkg::SAMPLE_W'(mid_hi);
        end else begin
            o_median = mrm_pkg::SAMPLE_W'(half);
        end
    end

endmodule

`default_nettype wire

FILE: src/multichannel_running_median.sv
// top level of the multichannel running median filter
//
// usage
// - i_in carries a channel number and a signed Q16.16 sample per word; o_out returns
//   the channel and the median of that channel's last WINDOW samples
// - every input word gives exactly one output word, in order
// - channels at or above CHANNELS leave all histories alone and return a median of zero
// - an accepted word passes the input register, then the result register, on its way to
//   o_out; one word per cycle sustained while o_out.ready holds high, set by the single
//   registered pass that reads, shifts and writes back a channel row in the same cycle
// - back-to-back words on the same channel see each other, since the row is read and
//   written back in the cycle the word moves into the result register
// - reset (synchronous, active low) empties both registers and zeroes every history,
//   so the first medians of a channel include zeros
// - when the receiver stalls the result word holds; one more word waits in the input
//   register, after which i_in.ready drops until o_out.ready returns
`default_nettype none

module multichannel_running_median (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mrm_in_if.sink           i_in,
    mrm_out_if.source        o_out
);

    // input register
    logic                             r_in_valid;
    logic [mrm_pkg::CH_W-1:0]         r_in_channel;
    mrm_pkg::t_sample                 r_in_sample;

    // result register
    logic                             r_out_valid;
    logic [mrm_pkg::CH_W-1:0]         r_out_channel;
    logic signed [mrm_pkg::SAMPLE_W-1:0] r_out_median;

    // per-channel histories, oldest sample at index 0
    mrm_pkg::t_row [mrm_pkg::CHANNELS-1:0] r_history;

    logic                             move;
    logic                             accept;
    logic                             ch_used;
    mrm_pkg::t_ch_idx                 ch_idx;
    mrm_pkg::t_row                    old_row;
    mrm_pkg::t_row                    n_row;
    logic signed [mrm_pkg::SAMPLE_W-1:0] row_median;
    logic signed [mrm_pkg::SAMPLE_W-1:0] n_out_median;

    // handshake: the input word moves on when the result slot is free or draining
    assign move        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || move;
    assign accept      = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.channel_out  = r_out_channel;
    assign o_out.median_value = r_out_median;

    // row lookup and shift of the new sample into the newest slot
    always_comb begin
        ch_used = int'(r_in_channel) < mrm_pkg::CHANNELS;
        ch_idx  = mrm_pkg::t_ch_idx'(r_in_channel);
        old_row = ch_used ? r_history[ch_idx] : '0;
        for (int i = 0; i < mrm_pkg::WINDOW - 1; i++) begin
            n_row[i] = old_row[i+1];
        end
        n_row[mrm_pkg::WINDOW-1] = r_in_sample;
    end

    mrm_median u_median (
        .i_row    (n_row),
        .o_median (row_median)
    );

    assign n_out_median = ch_used ? row_median : '0;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept || (r_in_valid && !move);
            r_out_valid <= move || (r_out_valid && !o_out.ready);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_channel <= i_in.channel;
            r_in_sample  <= i_in.sample[mrm_pkg::KEEP_BITS-1:0];
        end
        if (move) begin
            r_out_channel <= r_in_channel;
            r_out_median  <= n_out_median;
        end
    end

    // history write-back in the cycle the word moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history <= '0;
        end else if (move && ch_used) begin
            r_history[ch_idx] <= n_row;
        end
    end

    // a waiting input word is never dropped
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !move) |=> r_in_valid)
        else $error("pending input word lost");

    // a word that moves always lands in the result register
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("moved word missing from result register");

    // histories only change when a word moves through
    a_hist_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !move |=> $stable(r_history))
        else $error("history changed without a word");

    // unused channels return zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (int'(o_out.channel_out) >= mrm_pkg::CHANNELS))
            |-> (o_out.median_value == '0))
        else $error("unused channel returned a nonzero median");

endmodule

`default_nettype wire

FILE: tb/tb_multichannel_running_median.sv
// self-checking testbench of the multichannel running median filter
`default_nettype none

module tb_multichannel_running_median;

    // cycles without any handshake before the run is called hung
    localparam int STALL_LIMIT = 1000;
    // length of the long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 120;
    // words offered while the receiver holds off
    localparam int PRESSURE_WORDS = 20;

    // ------------------------------------------------------------------
    // per-channel history mirror, median prediction and result checking
    // ------------------------------------------------------------------
    class median_tracker;
        typedef struct packed {
            logic [mrm_pkg::CH_W-1:0]     ch;
            logic [mrm_pkg::SAMPLE_W-1:0] med;
        } t_median_word;

        // samples held sign-extended to 64 bits, oldest at index 0
        logic signed [63:0] hist [mrm_pkg::CHANNELS][mrm_pkg::WINDOW];
        t_median_word       pending_medians [$];
        int                 mismatches;

        function new();
            foreach (hist[c, k]) hist[c][k] = '0;
            mismatches = 0;
        endfunction

        // shift an accepted sample into its channel and queue the median it gives
        function void note_sample(logic [mrm_pkg::CH_W-1:0] ch,
                                  logic [mrm_pkg::SAMPLE_W-1:0] s);
            logic signed [63:0] row [mrm_pkg::WINDOW];
            logic signed [63:0] key;
            logic signed [63:0] sum;
            logic signed [63:0] half;
            logic [63:0]        mask;
            logic [63:0]        wide;
            t_median_word       w;
            int                 i;
            int                 j;
            int                 lo;
            w.ch  = ch;
            w.med = '0;
            if (ch < mrm_pkg::CHANNELS) begin
                // keep only the low KEEP_BITS bits, read as two's complement
                mask = (64'd1 << mrm_pkg::KEEP_BITS) - 64'd1;
                wide = {{(64 - mrm_pkg::SAMPLE_W){1'b0}}, s} & mask;
                if (wide[mrm_pkg::KEEP_BITS-1])
                    wide = wide | ~mask;
                for (i = 0; i < mrm_pkg::WINDOW - 1; i++)
                    hist[ch][i] = hist[ch][i+1];
                hist[ch][mrm_pkg::WINDOW-1] = wide;
                for (i = 0; i < mrm_pkg::WINDOW; i++)
                    row[i] = hist[ch][i];
                // insertion sort, signed ascending
                for (i = 1; i < mrm_pkg::WINDOW; i++) begin
                    key = row[i];
                    j   = i - 1;
                    while (j >= 0 && row[j] > key) begin
                        row[j+1] = row[j];
                        j--;
                    end
                    row[j+1] = key;
                end
                if (mrm_pkg::ODD_WINDOW) begin
                    w.med = row[mrm_pkg::MID][mrm_pkg::SAMPLE_W-1:0];
                end else begin
                    // full-width sum, then arithmetic halving
                    lo    = mrm_pkg::MID - 1;
                    sum   = row[mrm_pkg::MID] + row[lo];
                    half  = sum >>> 1;
                    w.med = half[mrm_pkg::SAMPLE_W-1:0];
                end
            end
            pending_medians.push_back(w);
        endfunction

        function void check_median(logic [mrm_pkg::CH_W-1:0] ch,
                                   logic [mrm_pkg::SAMPLE_W-1:0] med);
            t_median_word w;
            if (pending_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected median word: ch %0d median %h", ch, med);
                return;
            end
            w = pending_medians.pop_front();
            if (w.ch !== ch || w.med !== med) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("median mismatch: expected ch %0d median %h, got ch %0d median %h",
                             w.ch, w.med, ch, med);
            end
        endfunction

        function int pending();
            return pending_medians.size();
        endfunction

        // medians still owed at the end count as failures
        function void close_out();
            t_median_word w;
            while (pending_medians.size() != 0) begin
                w = pending_medians.pop_front();
                mismatches++;
                if (mismatches <= 10)
                    $display("median never returned: ch %0d median %h", w.ch, w.med);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    mrm_in_if  sample_ch ();
    mrm_out_if median_ch ();

    multichannel_running_median u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (median_ch)
    );

    median_tracker tracker;

    // idling switches per phase, and the long hold-off request
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;

    // random content state: channel bursts and repeated samples
    logic [mrm_pkg::CH_W-1:0]     last_ch;
    logic [mrm_pkg::SAMPLE_W-1:0] last_sample;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly a short one, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long counted hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        median_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // long stall so both registers fill and the input backs up
                median_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                median_ch.ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end else begin
                median_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: note accepted samples before checking returned medians
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready)
                tracker.note_sample(sample_ch.channel, sample_ch.sample);
            if (median_ch.valid && median_ch.ready)
                tracker.check_median(median_ch.channel_out, median_ch.median_value);
        end
    end

    // watchdog: ends a run in which no word moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((sample_ch.valid && sample_ch.ready) || (median_ch.valid && median_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("multichannel_running_median regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------

    // offer one word and hold it until accepted; maybe idle afterwards
    task automatic send_word(input logic [mrm_pkg::CH_W-1:0] ch,
                             input logic [mrm_pkg::SAMPLE_W-1:0] s);
        sample_ch.valid   <= 1'b1;
        sample_ch.channel <= ch;
        sample_ch.sample  <= s;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every queued median has come back
    task automatic wait_for_medians();
        sample_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        // two-stage pipeline, plus margin for any stray word
        repeat (4) @(posedge i_clk);
    endtask

    // random sample: full range, near zero for ties, repeats, extremes, whole Q16.16
    function automatic logic [mrm_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        logic [mrm_pkg::SAMPLE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = $urandom();
        end else if (r < 60) begin
            v = mrm_pkg::SAMPLE_W'($urandom_range(0, 8)) - mrm_pkg::SAMPLE_W'(4);
        end else if (r < 72) begin
            v = last_sample;
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       v = {1'b0, {(mrm_pkg::SAMPLE_W-1){1'b1}}};
                1:       v = {1'b1, {(mrm_pkg::SAMPLE_W-1){1'b0}}};
                2:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = {16'($urandom_range(0, 65535)), 16'd0};
        end
        return v;
    endfunction

    task automatic run_random(input int count);
        logic [mrm_pkg::CH_W-1:0]     ch;
        logic [mrm_pkg::SAMPLE_W-1:0] s;
        repeat (count) begin
            // bursts on one channel exercise back-to-back row updates
            if ($urandom_range(0, 1) == 0)
                ch = last_ch;
            else
                ch = mrm_pkg::CH_W'($urandom_range(0, (1 << mrm_pkg::CH_W) - 1));
            s           = pick_sample();
            last_ch     = ch;
            last_sample = s;
            send_word(ch, s);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main
        tracker           = new();
        tx_idle_en        = 1'b0;
        rx_idle_en        = 1'b0;
        hold_req          = 1'b0;
        last_ch           = '0;
        last_sample       = '0;
        i_rst_n           <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.channel <= '0;
        sample_ch.sample  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes against the zeroed history, then a full window of them
        send_word(3'd0, 32'h7fff_ffff);
        send_word(3'd0, 32'h8000_0000);
        send_word(3'd0, 32'h8000_0000);
        send_word(3'd0, 32'h7fff_ffff);
        send_word(3'd0, 32'hffff_ffff);
        send_word(3'd0, 32'h0000_0001);
        send_word(3'd0, 32'h0000_0000);
        // highest channel, rising then wrapping
        send_word(3'd7, 32'h8000_0000);
        send_word(3'd7, 32'hffff_ffff);
        send_word(3'd7, 32'h7fff_ffff);
        // one word on each remaining channel, first median includes two zeros
        send_word(3'd1, 32'h0001_0000);
        send_word(3'd2, 32'hffff_0000);
        send_word(3'd3, 32'h0000_8000);
        send_word(3'd4, 32'h5555_5555);
        send_word(3'd5, 32'haaaa_aaaa);
        send_word(3'd6, 32'h7fff_0000);
        // ties: the same value filling a window
        send_word(3'd3, 32'h1234_5678);
        send_word(3'd3, 32'h1234_5678);
        send_word(3'd3, 32'h1234_5678);
        // interleaved channels must keep separate histories
        send_word(3'd2, 32'h0000_0002);
        send_word(3'd5, 32'h0000_0005);
        send_word(3'd2, 32'hffff_fffe);
        send_word(3'd5, 32'hffff_fffb);
        wait_for_medians();

        // full rate, no idling on either side
        run_random(300);

        // random idling on both sides
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random(400);

        // receiver holds off while the sender keeps offering at full rate
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        run_random(PRESSURE_WORDS);

        // sender pauses until every median is back
        wait_for_medians();

        // receiver idling only
        rx_idle_en = 1'b1;
        run_random(380);

        // sender idling only
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b0;
        run_random(250);

        wait_for_medians();
        tracker.close_out();
        if (tracker.mismatches == 0)
            $display("multichannel_running_median regression: pass");
        else
            $display("multichannel_running_median regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/mrm_pkg.sv
src/mrm_if.sv
src/mrm_median.sv
src/multichannel_running_median.sv
tb/tb_multichannel_running_median.sv
